/* rtl/bdad_pkg.sv */
`default_nettype none

package bdad_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int METRIC_W  = 16;
    localparam int RATIO_W   = 8;
    localparam int COUNT_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd128;
    localparam logic [COUNT_W-1:0] ALARM_RESET = 8'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hFF;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_EVAL = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ALERT_NORMAL     = 2'd0,
        ALERT_SUSPICIOUS = 2'd1,
        ALERT_ALARM      = 2'd2
    } t_alert;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DROP_RATIO  = 1'b0,
        CFG_ALARM_COUNT = 1'b1
    } t_cfg_index;

endpackage

`default_nettype wire

/* rtl/baseline_drop_alert_detector.sv */
// An evaluate word passes from the A stage through the B stage into the output register, where
// it waits until it is taken; a push word yields no result.
// Throughput: one word per cycle when no result stalls; pushes and evaluations in any order.
// The pair ring is one synchronous memory read at accept and written back in the cycle after.
// Reset clears the sums, slot pointer, fill count and run counter and loads config defaults;
// ring entries not yet written since reset read as zero through the fill count.
`default_nettype none

module baseline_drop_alert_detector
    import bdad_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_opcode,
    input  wire logic [METRIC_W-1:0]   i_rmssd_value,
    input  wire logic [METRIC_W-1:0]   i_sdnn_value,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [STATUS_W-1:0]        o_alert_status,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = METRIC_W + SLOT_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_LEVEL = FILL_W'(WINDOW_DEPTH);

    logic [2*METRIC_W-1:0] r_ring_mem [WINDOW_DEPTH];
    logic [2*METRIC_W-1:0] r_ring_rd;

    logic [RATIO_W-1:0]  r_drop_ratio;
    logic [COUNT_W-1:0]  r_alarm_count;
    logic [SLOT_W-1:0]   r_slot;
    logic [FILL_W-1:0]   r_fill;
    logic [SUM_W-1:0]    r_rm_sum;
    logic [SUM_W-1:0]    r_sd_sum;

    logic                r_a_valid;
    logic                r_a_op;
    logic                r_a_full;
    logic [SLOT_W-1:0]   r_a_slot;
    logic [METRIC_W-1:0] r_a_rm;
    logic [METRIC_W-1:0] r_a_sd;

    logic [SLOT_W-1:0]   n_slot;
    logic [FILL_W-1:0]   n_fill;
    logic [SUM_W-1:0]    n_rm_sum;
    logic [SUM_W-1:0]    n_sd_sum;
    logic [METRIC_W-1:0] old_rm;
    logic [METRIC_W-1:0] old_sd;

    logic                in_accept;
    logic                a_free;
    logic                push_retire;
    logic                eval_valid;
    logic                eval_ready;
    logic                window_full;

    assign window_full = (r_fill == FULL_LEVEL);
    assign push_retire = r_a_valid && (r_a_op == OP_PUSH);
    assign eval_valid  = r_a_valid && (r_a_op == OP_EVAL);
    assign a_free      = !r_a_valid || push_retire || eval_ready;
    assign o_stall     = !a_free;
    assign in_accept   = i_valid && a_free;

    always_ff @(posedge i_clk) begin
        if (push_retire) begin
            r_ring_mem[r_a_slot] <= {r_a_rm, r_a_sd};
        end
        if (in_accept) begin
            r_ring_rd <= r_ring_mem[r_slot];
        end
    end

    // Until the window has filled, the slot being replaced was never written.
    always_comb begin
        old_rm   = r_a_full ? r_ring_rd[2*METRIC_W-1:METRIC_W] : '0;
        old_sd   = r_a_full ? r_ring_rd[METRIC_W-1:0] : '0;
        n_rm_sum = r_rm_sum - SUM_W'(old_rm) + SUM_W'(r_a_rm);
        n_sd_sum = r_sd_sum - SUM_W'(old_sd) + SUM_W'(r_a_sd);
        n_slot   = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
        n_fill   = window_full ? r_fill : r_fill + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_op   <= i_opcode;
            r_a_full <= window_full;
            r_a_slot <= r_slot;
            r_a_rm   <= i_rmssd_value;
            r_a_sd   <= i_sdnn_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid     <= 1'b0;
            r_slot        <= '0;
            r_fill        <= '0;
            r_rm_sum      <= '0;
            r_sd_sum      <= '0;
            r_drop_ratio  <= RATIO_RESET;
            r_alarm_count <= ALARM_RESET;
        end else begin
            if (a_free) begin
                r_a_valid <= i_valid;
            end
            if (in_accept && (i_opcode == OP_PUSH)) begin
                r_slot <= n_slot;
                r_fill <= n_fill;
            end
            if (push_retire) begin
                r_rm_sum <= n_rm_sum;
                r_sd_sum <= n_sd_sum;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_DROP_RATIO:  r_drop_ratio  <= i_cfg_data;
                    CFG_ALARM_COUNT: r_alarm_count <= i_cfg_data;
                endcase
            end
        end
    end

    bdad_alert_unit #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SUM_W        (SUM_W)
    ) u_alert (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_eval_valid   (eval_valid),
        .o_eval_ready   (eval_ready),
        .i_full         (r_a_full),
        .i_rm_value     (r_a_rm),
        .i_sd_value     (r_a_sd),
        .i_rm_sum       (r_rm_sum),
        .i_sd_sum       (r_sd_sum),
        .i_drop_ratio   (r_drop_ratio),
        .i_alarm_count  (r_alarm_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_alert_status (o_alert_status)
    );

endmodule

`default_nettype wire

/* rtl/bdad_alert_unit.sv */
`default_nettype none

module bdad_alert_unit
    import bdad_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEPTH_DEF,
    parameter int SUM_W        = METRIC_W + $clog2(WINDOW_DEPTH)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_eval_valid,
    output logic                     o_eval_ready,
    input  wire logic                i_full,
    input  wire logic [METRIC_W-1:0] i_rm_value,
    input  wire logic [METRIC_W-1:0] i_sd_value,
    input  wire logic [SUM_W-1:0]    i_rm_sum,
    input  wire logic [SUM_W-1:0]    i_sd_sum,
    input  wire logic [RATIO_W-1:0]  i_drop_ratio,
    input  wire logic [COUNT_W-1:0]  i_alarm_count,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [STATUS_W-1:0]      o_alert_status
);

    localparam int PROD_W = RATIO_W + SUM_W;
    localparam logic [PROD_W-1:0] LHS_SCALE = PROD_W'((2 ** RATIO_W) * WINDOW_DEPTH);

    logic               r_b_valid;
    logic               r_b_full;
    logic [PROD_W-1:0]  r_b_rm_lhs;
    logic [PROD_W-1:0]  r_b_rm_rhs;
    logic [PROD_W-1:0]  r_b_sd_lhs;
    logic [PROD_W-1:0]  r_b_sd_rhs;
    logic               r_out_valid;
    t_alert             r_out_status;
    logic [COUNT_W-1:0] r_run;

    logic               out_free;
    logic               b_move;
    logic               abnormal;
    logic [COUNT_W-1:0] run_inc;
    logic [COUNT_W-1:0] n_run;
    t_alert             n_status;

    assign out_free     = !r_out_valid || !i_stall;
    assign b_move       = r_b_valid && out_free;
    assign o_eval_ready = !r_b_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (i_eval_valid && o_eval_ready) begin
            r_b_full   <= i_full;
            r_b_rm_lhs <= PROD_W'(i_rm_value) * LHS_SCALE;
            r_b_rm_rhs <= PROD_W'(i_drop_ratio) * PROD_W'(i_rm_sum);
            r_b_sd_lhs <= PROD_W'(i_sd_value) * LHS_SCALE;
            r_b_sd_rhs <= PROD_W'(i_drop_ratio) * PROD_W'(i_sd_sum);
        end
    end

    // An empty window sum or a zero ratio gives a zero right side, so the
    // strict compare never flags that metric.
    always_comb begin
        abnormal = r_b_full && (r_b_rm_lhs < r_b_rm_rhs) && (r_b_sd_lhs < r_b_sd_rhs);
        run_inc  = (r_run == COUNT_MAX) ? r_run : r_run + 1'b1;
        if (!abnormal) begin
            n_run    = '0;
            n_status = ALERT_NORMAL;
        end else if (run_inc >= i_alarm_count) begin
            n_run    = '0;
            n_status = ALERT_ALARM;
        end else begin
            n_run    = run_inc;
            n_status = ALERT_SUSPICIOUS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_run       <= '0;
        end else begin
            if (o_eval_ready) begin
                r_b_valid <= i_eval_valid;
            end
            if (out_free) begin
                r_out_valid <= r_b_valid;
            end
            if (b_move) begin
                r_run <= n_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_out_status <= n_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_alert_status = r_out_status;

endmodule

`default_nettype wire

/* rtl/bdad_checker.sv */
`default_nettype none

module bdad_checker
    import bdad_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_stall,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic [STATUS_W-1:0] o_alert_status
);

    // A word held at the output stays until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_alert_status))
        else $error("output word changed while stalled");

    // Input back-pressure only ever comes from a stalled result.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result");

    // No result can appear after reset before a word has passed the pipeline stages.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid ##1 !o_valid)
        else $error("result appeared too early after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_alert_status == ALERT_NORMAL) || (o_alert_status == ALERT_SUSPICIOUS)
                    || (o_alert_status == ALERT_ALARM))
        else $error("undefined alert status");

endmodule

bind baseline_drop_alert_detector bdad_checker u_bdad_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_alert_status (o_alert_status)
);

`default_nettype wire
